### rtl/rcsf_pkg.sv
// rcsf_pkg: shared types and constants for the RC channel smoothing filter.
// No dependencies.
package rcsf_pkg;

  localparam int unsigned PW_W         = 12;
  localparam int unsigned CH_W         = 3;
  localparam int unsigned WINDOW_LEN   = 4;
  localparam int unsigned SLOT_W       = 2;
  localparam int unsigned SUM_W        = PW_W + SLOT_W;
  localparam int unsigned NUM_CHANNELS = 6;

  localparam logic [PW_W-1:0]   VALID_LOW  = PW_W'(750);
  localparam logic [PW_W-1:0]   VALID_HIGH = PW_W'(2250);
  localparam logic [PW_W:0]     DEADBAND   = (PW_W+1)'(3);
  localparam logic [PW_W-1:0]   PULLBACK   = PW_W'(2);
  localparam logic [PW_W-1:0]   HELD_RESET = PW_W'(1500);
  localparam logic [PW_W-1:0]   MID_RESET  = PW_W'(1500);
  localparam logic [SUM_W-1:0]  ROUND_ADD  = SUM_W'(2);

  // One memory row: a channel's sample window and its held value.
  typedef struct packed {
    logic [PW_W-1:0]                  held;
    logic [WINDOW_LEN-1:0][PW_W-1:0]  win;
  } row_t;

  localparam row_t ROW_RESET = '{held: HELD_RESET, win: '0};

endpackage

### rtl/rcsf_if.sv
// rcsf_if: valid/ready channel interfaces for the RC channel smoothing filter.
// Depends on rcsf_pkg.
interface rcsf_in_if import rcsf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] channel;
  logic [PW_W-1:0] pulse_width;

  modport source (output valid, channel, pulse_width, input ready);
  modport sink   (input valid, channel, pulse_width, output ready);
endinterface

interface rcsf_out_if import rcsf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_channel;
  logic [PW_W-1:0] held_value;

  modport source (output valid, out_channel, held_value, input ready);
  modport sink   (input valid, out_channel, held_value, output ready);
endinterface

interface rcsf_cfg_if import rcsf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PW_W-1:0] mid_value;

  modport source (output valid, mid_value, input ready);
  modport sink   (input valid, mid_value, output ready);
endinterface

### rtl/rc_channel_smoothing_filter.sv
// rc_channel_smoothing_filter: per-channel 4-sample moving average with deadband.
// Depends on rcsf_pkg and the interfaces in rcsf_if.sv.
//
//  channel | modport | payload
//  --------+---------+-------------------------------
//  in_i    | sink    | channel, pulse_width
//  cfg_i   | sink    | mid_value (always ready)
//  out_o   | source  | out_channel, held_value
//
// One item per cycle while out_o is not stalled; an accepted item passes the update
// stage register and then the output register before out_o.valid rises.
// Rate is set by the row memory: one read at accept, one write-back as the item
// leaves the update stage, with the written row forwarded to a same-channel
// item that follows. Reset clears the row valid bits; an unwritten row reads as
// zero window and held value 1500. No clearing pass is needed.
// A stalled out_o holds one result; one more item waits in the update stage.
module rc_channel_smoothing_filter import rcsf_pkg::*; #(
  parameter int unsigned NumChannels = NUM_CHANNELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rcsf_in_if.sink     in_i,
  rcsf_cfg_if.sink    cfg_i,
  rcsf_out_if.source  out_o
);

  localparam int unsigned AW = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  row_t                    mem [NumChannels];
  logic [NumChannels-1:0]  row_vld_q;

  logic [PW_W-1:0]   mid_q;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic              s1_vld_q;
  logic [AW-1:0]     s1_ch_q;
  logic [PW_W-1:0]   s1_pw_q;
  logic [SLOT_W-1:0] s1_slot_q;
  logic              fwd_q;
  logic              rdv_q;
  row_t              rd_q;
  row_t              wb_q;

  logic              out_vld_q;
  logic [CH_W-1:0]   out_ch_q;
  logic [PW_W-1:0]   out_held_q;

  logic              advance, in_fire, in_range, s1_fire;
  logic [AW-1:0]     in_addr;
  logic [PW_W-1:0]   pw_sub;
  row_t              base_row, new_row;
  logic [SUM_W-1:0]  sum;
  logic [PW_W-1:0]   mean, held_new;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= MID_RESET;
    end else if (cfg_i.valid) begin
      mid_q <= cfg_i.mid_value;
    end
  end

  assign advance     = !out_vld_q || out_o.ready;
  assign in_i.ready  = advance || !s1_vld_q;
  assign in_fire     = in_i.valid && in_i.ready;
  assign in_range    = {1'b0, in_i.channel} < (CH_W+1)'(NumChannels);
  assign in_addr     = in_i.channel[AW-1:0];
  assign s1_fire     = s1_vld_q && advance;

  assign slot_d = (in_fire && in_i.channel == '0) ? slot_q + SLOT_W'(1) : slot_q;
  assign pw_sub = (in_i.pulse_width < VALID_LOW || in_i.pulse_width > VALID_HIGH)
                  ? mid_q : in_i.pulse_width;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      slot_q <= slot_d;
      if (in_fire) begin
        s1_vld_q <= in_range;
      end else if (s1_fire) begin
        s1_vld_q <= 1'b0;
      end
    end
  end

  // Read at accept; forward the row written back at the same edge.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ch_q   <= in_addr;
      s1_pw_q   <= pw_sub;
      s1_slot_q <= slot_d;
      rd_q      <= mem[in_addr];
      rdv_q     <= row_vld_q[in_addr];
      fwd_q     <= s1_fire && (s1_ch_q == in_addr);
    end
    if (s1_fire) begin
      mem[s1_ch_q] <= new_row;
      wb_q         <= new_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (s1_fire) begin
      row_vld_q[s1_ch_q] <= 1'b1;
    end
  end

  always_comb begin
    base_row = fwd_q ? wb_q : (rdv_q ? rd_q : ROW_RESET);
    new_row  = base_row;
    new_row.win[s1_slot_q] = s1_pw_q;
    sum = '0;
    for (int k = 0; k < WINDOW_LEN; k++) begin
      sum = sum + SUM_W'(new_row.win[k]);
    end
    mean = PW_W'((sum + ROUND_ADD) >> SLOT_W);
    held_new = base_row.held;
    if ({1'b0, mean} + DEADBAND < {1'b0, base_row.held}) begin
      held_new = mean + PULLBACK;
    end else if ({1'b0, mean} > {1'b0, base_row.held} + DEADBAND) begin
      held_new = mean - PULLBACK;
    end
    new_row.held = held_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_ch_q   <= CH_W'(s1_ch_q);
      out_held_q <= held_new;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.out_channel = out_ch_q;
  assign out_o.held_value  = out_held_q;

  a_drop_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_range) |=> !s1_vld_q)
    else $error("out-of-range channel entered update stage");

  a_take_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_range) |=> s1_vld_q)
    else $error("accepted item lost before update stage");

  a_slot_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && in_i.channel == '0) |=> $stable(slot_q))
    else $error("write slot moved without a channel-0 item");

  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_vld_q)
    else $error("update stage result not presented");

endmodule
